// ----- rtl/core/smpq_pkg.sv -----
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and constants for the staged min priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned DefCapacity = 64;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_TRANSFER = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DATA  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } rsp_t;

endpackage

// ----- rtl/core/staged_min_priority_queue.sv -----
// ----------------------------------------------------------------------------
// staged_min_priority_queue
// FIFO staging queue in front of a binary min-heap, both held in RAM.
// ----------------------------------------------------------------------------
// Usage: drive req and raise start while busy is low; the item is taken at
// that edge. Exactly one result per item appears on rsp for one cycle, marked
// by done, and the block is idle again in that same cycle, so the next start
// may be taken while the result is shown. The receiver cannot stall.
// Flow after the accepting edge: push and pop on empty raise done directly;
// a pop from the staging FIFO reads the FIFO head first. A heap pop reads
// the root, then the last entry, then sifts that entry down, each level of
// sift-down visited taking a left read, a right read and a compare and
// write, with a final write when the hole reaches a leaf. A transfer takes
// each staged entry in turn and sifts it up, each level it rises taking a
// parent read and a compare and write. Items are handled one at a time;
// the single read port of each RAM sets the pace.
// Reset: synchronous rst clears state, counters, done and rsp; the RAM
// contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module staged_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::DefCapacity
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  smpq_pkg::req_t  req,
  output logic            busy,
  output logic            done,
  output smpq_pkg::rsp_t  rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SPOP  = 11'b00000000010,
    S_HTOP  = 11'b00000000100,
    S_HLAST = 11'b00000001000,
    S_DRD   = 11'b00000010000,
    S_DL    = 11'b00000100000,
    S_DR    = 11'b00001000000,
    S_TRD   = 11'b00010000000,
    S_TGET  = 11'b00100000000,
    S_URD   = 11'b01000000000,
    S_UCMP  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic signed [31:0] stage_mem [CAPACITY];
  logic signed [31:0] heap_mem  [CAPACITY];

  logic [AW-1:0] stage_head, stage_head_next;
  logic [CW-1:0] stage_count, stage_count_next;
  logic [CW-1:0] heap_count, heap_count_next;

  // stage ram port
  logic               s_we;
  logic [AW-1:0]      s_waddr, s_raddr;
  logic signed [31:0] s_wdata, s_rdata;
  // heap ram port
  logic               h_we;
  logic [AW-1:0]      h_waddr, h_raddr;
  logic signed [31:0] h_wdata, h_rdata;

  logic signed [31:0] key, key_next;      // value being sifted
  logic signed [31:0] lval, lval_next;    // left child value
  logic signed [31:0] top, top_next;
  logic [AW-1:0]      idx, idx_next;      // hole position
  logic               done_next;
  smpq_pkg::rsp_t     rsp_next;

  logic [AW:0]        lchild;
  logic [LW-1:0]      rchild;
  logic [AW-1:0]      parent;
  logic [LW-1:0]      tail_sum;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      head_inc;
  logic               full;
  logic               use_r;
  logic signed [31:0] cval;
  logic [AW-1:0]      cidx;

  always_ff @(posedge clk) begin
    if (s_we) stage_mem[s_waddr] <= s_wdata;
    s_rdata <= stage_mem[s_raddr];
    if (h_we) heap_mem[h_waddr] <= h_wdata;
    h_rdata <= heap_mem[h_raddr];
  end

  always_comb begin
    tail_sum = LW'(stage_head) + LW'(stage_count);
    tail = (tail_sum >= LW'(CAPACITY)) ? AW'(tail_sum - LW'(CAPACITY)) : AW'(tail_sum);
    head_inc = (stage_head == AW'(CAPACITY - 1)) ? '0 : stage_head + 1'b1;
    full = ((CW+1)'(stage_count) + (CW+1)'(heap_count)) >= (CW+1)'(CAPACITY);
    lchild = {idx, 1'b1};
    rchild = {1'b0, lchild} + 1'b1;
    parent = (idx - 1'b1) >> 1;
    // right child only counts when it exists
    use_r = (rchild < LW'(heap_count)) && (h_rdata < lval);
    cval = use_r ? h_rdata : lval;
    cidx = use_r ? AW'(rchild) : AW'(lchild);
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    stage_head_next  = stage_head;
    stage_count_next = stage_count;
    heap_count_next  = heap_count;
    key_next         = key;
    lval_next        = lval;
    top_next         = top;
    idx_next         = idx;
    done_next        = 1'b0;
    rsp_next         = rsp;
    s_we    = 1'b0;
    s_waddr = tail;
    s_wdata = req.value;
    s_raddr = stage_head;
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = key;
    h_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          rsp_next = '0;
          unique case (req.op) inside
            smpq_pkg::OP_PUSH: begin
              if (full) begin
                rsp_next.status = smpq_pkg::ST_FULL;
              end else begin
                s_we             = 1'b1;
                stage_count_next = stage_count + 1'b1;
              end
              done_next = 1'b1;
            end
            smpq_pkg::OP_POP: begin
              if (heap_count != '0) begin
                heap_count_next = heap_count - 1'b1;
                state_next      = S_HTOP;
              end else if (stage_count != '0) begin
                state_next = S_SPOP;
              end else begin
                rsp_next.status = smpq_pkg::ST_EMPTY;
                done_next       = 1'b1;
              end
            end
            smpq_pkg::OP_TRANSFER, smpq_pkg::OP_SPARE: state_next = S_TRD;
          endcase
        end
      end
      S_SPOP: begin
        rsp_next.data    = s_rdata;
        rsp_next.status  = smpq_pkg::ST_DATA;
        stage_head_next  = head_inc;
        stage_count_next = stage_count - 1'b1;
        done_next        = 1'b1;
        state_next       = S_IDLE;
      end
      // heap pop: root, then last entry, then sift the last one down
      S_HTOP: begin
        top_next   = h_rdata;
        h_raddr    = AW'(heap_count);
        state_next = S_HLAST;
      end
      S_HLAST: begin
        key_next = h_rdata;
        idx_next = '0;
        if (heap_count == '0) begin
          rsp_next.data   = top;
          rsp_next.status = smpq_pkg::ST_DATA;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        if (LW'(lchild) >= LW'(heap_count)) begin
          h_we            = 1'b1;
          rsp_next.data   = top;
          rsp_next.status = smpq_pkg::ST_DATA;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          h_raddr    = AW'(lchild);
          state_next = S_DL;
        end
      end
      S_DL: begin
        lval_next  = h_rdata;
        h_raddr    = AW'(rchild);
        state_next = S_DR;
      end
      S_DR: begin
        h_we = 1'b1;
        if (cval < key) begin
          h_wdata    = cval;
          idx_next   = cidx;
          state_next = S_DRD;
        end else begin
          rsp_next.data   = top;
          rsp_next.status = smpq_pkg::ST_DATA;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end
      end
      // transfer: pull each staged item in turn, sift it up
      S_TRD: begin
        if (stage_count == '0) begin
          rsp_next.status = smpq_pkg::ST_DONE;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_TGET;
        end
      end
      S_TGET: begin
        key_next         = s_rdata;
        idx_next         = AW'(heap_count);
        heap_count_next  = heap_count + 1'b1;
        stage_head_next  = head_inc;
        stage_count_next = stage_count - 1'b1;
        state_next       = S_URD;
      end
      S_URD: begin
        if (idx == '0) begin
          h_we       = 1'b1;
          state_next = S_TRD;
        end else begin
          h_raddr    = parent;
          state_next = S_UCMP;
        end
      end
      S_UCMP: begin
        h_we = 1'b1;
        if (key < h_rdata) begin
          h_wdata    = h_rdata;
          idx_next   = parent;
          state_next = S_URD;
        end else begin
          state_next = S_TRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stage_head  <= '0;
      stage_count <= '0;
      heap_count  <= '0;
      done        <= 1'b0;
      rsp         <= '0;
    end else begin
      state       <= state_next;
      stage_head  <= stage_head_next;
      stage_count <= stage_count_next;
      heap_count  <= heap_count_next;
      done        <= done_next;
      rsp         <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    key  <= key_next;
    lval <= lval_next;
    top  <= top_next;
    idx  <= idx_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    32'(stage_count) + 32'(heap_count) <= CAPACITY)
    else $error("occupancy overflow");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op != smpq_pkg::OP_PUSH && !(req.op == smpq_pkg::OP_POP
      && heap_count == '0 && stage_count == '0)) |=> busy)
    else $error("item dropped");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");

endmodule
